// ===== src/mcmp_pkg.sv =====
// types, codes and constants shared by the midi channel message parser
package mcmp_pkg;

    localparam int unsigned TICK_RATE = 48000;
    localparam int unsigned HOLD_MS   = 15000;
    localparam logic [19:0] TIMEOUT_RESET = 20'(TICK_RATE * HOLD_MS / 1000);

    localparam logic [13:0] CENTER    = 14'h2000;
    localparam logic [13:0] KEEP_LOW  = 14'h007F;
    localparam logic [13:0] KEEP_HIGH = 14'h3F80;

    localparam logic [2:0] TYPE_SYSTEM = 3'h7;
    localparam logic [3:0] SYS_CLOCK   = 4'h8;
    localparam logic [3:0] SYS_START   = 4'hA;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_OVERRUN = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        H_IGNORE, H_OFF_NOTE, H_OFF_VEL, H_ON_NOTE, H_ON_VEL,
        H_CC_NUM, H_CC_SKIP, H_MW_HI, H_MW_LO, H_DAMPER, H_PANIC,
        H_BR_HI, H_BR_LO, H_PRESSURE, H_PW_LSB, H_PW_MSB
    } handler_t;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_NOTE_ON  = 4'd1,
        EV_NOTE_OFF = 4'd2,
        EV_DAMPER   = 4'd3,
        EV_PANIC    = 4'd4,
        EV_AFTER    = 4'd5,
        EV_PITCH    = 4'd6,
        EV_MODWHEEL = 4'd7,
        EV_BREATH   = 4'd8,
        EV_CLOCK    = 4'd9,
        EV_START    = 4'd10
    } event_t;

    localparam logic [6:0] CC_MW_HI  = 7'd1;
    localparam logic [6:0] CC_BR_HI  = 7'd2;
    localparam logic [6:0] CC_MW_LO  = 7'd33;
    localparam logic [6:0] CC_BR_LO  = 7'd34;
    localparam logic [6:0] CC_DAMPER = 7'd64;
    localparam logic [6:0] CC_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_NOTES_OFF = 7'd123;

    localparam logic REG_LISTEN  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef struct packed {
        handler_t    handler;
        logic [6:0]  first_data;
        logic [13:0] modwheel;
        logic [13:0] breath;
        logic [19:0] silence;
    } parse_state_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [6:0]  note_number;
        logic [6:0]  value7;
        logic [13:0] pitch_bend;
        logic [13:0] controller14;
    } result_t;

endpackage

// ===== src/mcmp_decode.sv =====
// combinational decode of one item against the running status state
module mcmp_decode
    import mcmp_pkg::*;
(
    input  parse_state_t state,
    input  logic [1:0]   op,
    input  logic [7:0]   rx_byte,
    input  logic [3:0]   listen_channel,
    input  logic [19:0]  status_timeout,
    output parse_state_t state_next,
    output result_t      result
);

    logic [6:0]  d;
    logic [2:0]  msg_type;
    logic [3:0]  chan;
    logic [19:0] silence_dec;

    assign d           = rx_byte[6:0];
    assign msg_type    = rx_byte[6:4];
    assign chan        = rx_byte[3:0];
    assign silence_dec = state.silence - 20'd1;

    always_comb begin
        state_next = state;
        result     = '0;
        case (op_t'(op))
            OP_BYTE: begin
                state_next.silence = status_timeout;
                if (rx_byte[7]) begin
                    if (msg_type == TYPE_SYSTEM) begin
                        if (chan == SYS_CLOCK) begin
                            result.event_res = EV_CLOCK;
                        end else if (chan == SYS_START) begin
                            result.event_res = EV_START;
                        end
                    end else if (chan == listen_channel) begin
                        case (msg_type)
                            3'd0:    state_next.handler = H_OFF_NOTE;
                            3'd1:    state_next.handler = H_ON_NOTE;
                            3'd3:    state_next.handler = H_CC_NUM;
                            3'd5:    state_next.handler = H_PRESSURE;
                            3'd6:    state_next.handler = H_PW_LSB;
                            default: state_next.handler = H_IGNORE;
                        endcase
                    end else begin
                        state_next.handler = H_IGNORE;
                    end
                end else begin
                    case (state.handler)
                        H_OFF_NOTE: begin
                            state_next.first_data = d;
                            state_next.handler    = H_OFF_VEL;
                        end
                        H_ON_NOTE: begin
                            state_next.first_data = d;
                            state_next.handler    = H_ON_VEL;
                        end
                        H_OFF_VEL, H_ON_VEL: begin
                            // note on with zero velocity counts as note off
                            result.event_res = (state.handler == H_ON_VEL && d != 7'd0)
                                             ? EV_NOTE_ON : EV_NOTE_OFF;
                            result.note_number = state.first_data;
                            result.value7      = d;
                            state_next.handler = (state.handler == H_ON_VEL)
                                               ? H_ON_NOTE : H_OFF_NOTE;
                        end
                        H_CC_NUM: begin
                            state_next.first_data = d;
                            if (d == CC_MW_HI) begin
                                state_next.handler = H_MW_HI;
                            end else if (d == CC_MW_LO) begin
                                state_next.handler = H_MW_LO;
                            end else if (d == CC_BR_HI) begin
                                state_next.handler = H_BR_HI;
                            end else if (d == CC_BR_LO) begin
                                state_next.handler = H_BR_LO;
                            end else if (d == CC_DAMPER) begin
                                state_next.handler = H_DAMPER;
                            end else if (d inside {CC_SOUND_OFF, CC_NOTES_OFF}) begin
                                state_next.handler = H_PANIC;
                            end else begin
                                state_next.handler = H_CC_SKIP;
                            end
                        end
                        H_CC_SKIP: begin
                            state_next.handler = H_CC_NUM;
                        end
                        H_MW_HI, H_MW_LO: begin
                            if (state.handler == H_MW_HI) begin
                                state_next.modwheel = (state.modwheel & KEEP_LOW) | {d, 7'd0};
                            end else begin
                                state_next.modwheel = (state.modwheel & KEEP_HIGH) | {7'd0, d};
                            end
                            result.event_res    = EV_MODWHEEL;
                            result.controller14 = state_next.modwheel;
                            state_next.handler  = H_CC_NUM;
                        end
                        H_BR_HI, H_BR_LO: begin
                            if (state.handler == H_BR_HI) begin
                                state_next.breath = (state.breath & KEEP_LOW) | {d, 7'd0};
                            end else begin
                                state_next.breath = (state.breath & KEEP_HIGH) | {7'd0, d};
                            end
                            result.event_res    = EV_BREATH;
                            result.controller14 = state_next.breath;
                            state_next.handler  = H_CC_NUM;
                        end
                        H_DAMPER: begin
                            result.event_res   = EV_DAMPER;
                            result.value7      = d;
                            state_next.handler = H_CC_NUM;
                        end
                        H_PANIC: begin
                            result.event_res   = EV_PANIC;
                            state_next.handler = H_CC_NUM;
                        end
                        H_PRESSURE: begin
                            result.event_res = EV_AFTER;
                            result.value7    = d;
                        end
                        H_PW_LSB: begin
                            state_next.first_data = d;
                            state_next.handler    = H_PW_MSB;
                        end
                        H_PW_MSB: begin
                            result.event_res   = EV_PITCH;
                            result.pitch_bend  = {d, state.first_data} - CENTER;
                            state_next.handler = H_PW_LSB;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_TICK: begin
                if (state.silence != 20'd0) begin
                    state_next.silence = silence_dec;
                    if (silence_dec == 20'd0) begin
                        state_next.handler = H_IGNORE;
                    end
                end
            end
            OP_OVERRUN: begin
                result.event_res = EV_PANIC;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/midi_channel_message_parser.sv =====
// midi channel message parser: input register, decode, result register
// a result shows on m_tvalid once its item has passed the input register and the decode into the result register
// throughput: one item per cycle while m_tready is high, one result per item, no bubbles
// a waiting result lets the input register take one more item, then s_tready drops
// reset (synchronous, aresetn low) empties both registers, sets the parser
// to ignore data with zeroed values and loads the register defaults
module midi_channel_message_parser
    import mcmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [6:0] note_number, [13:7] value7,
                                   // [27:14] pitch_bend, [41:28] controller14, rest zero
    output logic [3:0]  m_tuser,   // [3:0] event_res
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         in_valid_reg;
    logic [1:0]   in_op_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    result_t      out_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result;
    logic [3:0]   listen_reg;
    logic [19:0]  timeout_reg;
    logic         advance;
    logic         cfg_write;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    mcmp_decode u_decode (
        .state          (state_reg),
        .op             (in_op_reg),
        .rx_byte        (in_byte_reg),
        .listen_channel (listen_reg),
        .status_timeout (timeout_reg),
        .state_next     (state_next),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{handler: H_IGNORE, default: '0};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_reg  <= 4'd0;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_LISTEN) begin
                listen_reg <= pwdata[3:0];
            end else begin
                timeout_reg <= pwdata[19:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_TIMEOUT) begin
            prdata = {12'd0, timeout_reg};
        end else begin
            prdata = {28'd0, listen_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {6'd0, out_reg.controller14, out_reg.pitch_bend,
                       out_reg.value7, out_reg.note_number};

endmodule

// ===== src/mcmp_checker.sv =====
// port level checks for the midi channel message parser, bound to the top level
module mcmp_checker
    import mcmp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // a stalled result holds its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= EV_START)
        else $error("event code out of range");

    // note field only carries a note for note events
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_NOTE_ON && m_tuser != EV_NOTE_OFF
        |-> m_tdata[6:0] == 7'd0)
        else $error("note number set on a non-note event");

    // pitch and controller fields only set by their own events
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_PITCH |-> m_tdata[27:14] == 14'd0)
        else $error("pitch value set on a non-pitch event");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_MODWHEEL && m_tuser != EV_BREATH
        |-> m_tdata[41:28] == 14'd0)
        else $error("controller value set on a wrong event");

endmodule

bind midi_channel_message_parser mcmp_checker u_mcmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
